[hw/rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C bit level master.
// Used by i2cm_core and i2c_bit_level_master_top; depends on nothing else.
`default_nettype none

package i2cm_pkg;

   localparam int unsigned TICK_W   = 16;
   localparam int unsigned LIMIT_W  = 8;
   localparam int unsigned MS_W     = 15;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BIDX_W   = 4;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [TICK_W-1:0]  HALF_BIT_RESET  = 16'd20;
   localparam logic [TICK_W-1:0]  CONDITION_RESET = 16'd40;
   localparam logic [TICK_W-1:0]  ACK_POLL_RESET  = 16'd160;
   localparam logic [LIMIT_W-1:0] POLL_LIMIT_RESET = 8'd200;
   localparam logic [TICK_W-1:0]  MS_TICKS_RESET  = 16'd1000;

   localparam logic [BIDX_W-1:0]  BITS_PER_BYTE   = 4'd8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE     = 3'd0,
      ACT_START    = 3'd1,
      ACT_STOP     = 3'd2,
      ACT_WRITE    = 3'd3,
      ACT_READ     = 3'd4,
      ACT_WAIT_SCL = 3'd5
   } i2cm_action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_BIT   = 3'd0,
      CSR_CONDITION  = 3'd1,
      CSR_ACK_POLL   = 3'd2,
      CSR_POLL_LIMIT = 3'd3,
      CSR_MS_TICKS   = 3'd4
   } i2cm_csr_type;

   typedef struct packed {
      logic [TICK_W-1:0]  half_bit_ticks;
      logic [TICK_W-1:0]  condition_ticks;
      logic [TICK_W-1:0]  ack_poll_ticks;
      logic [LIMIT_W-1:0] ack_poll_limit;
      logic [TICK_W-1:0]  ms_ticks;
   } i2cm_cfg_type;

   typedef struct packed {
      logic              scl_drive_low;
      logic              sda_drive_low;
      logic              busy_res;
      logic              done_res;
      logic              ack_seen;
      logic              scl_released;
      logic [BYTE_W-1:0] read_data;
   } i2cm_result_type;

   // A timing register of zero behaves as a single tick.
   function automatic logic [TICK_W-1:0] period(input logic [TICK_W-1:0] v);
      period = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/i2cm_core.sv]
// Bus sequencer of the I2C bit level master: phase register, timers and shifters.
// Computes one tick's result from the stored state and the accepted input; uses i2cm_pkg.
`default_nettype none

module i2cm_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step_en,
   input  wire logic [2:0]                 action,
   input  wire logic [7:0]                 write_data,
   input  wire logic                       send_ack,
   input  wire logic [14:0]                wait_ms,
   input  wire logic                       sda_in,
   input  wire logic                       scl_in,
   input  wire i2cm_pkg::i2cm_cfg_type     cfg,
   output i2cm_pkg::i2cm_result_type       result
);
   import i2cm_pkg::*;

   typedef enum logic [16:0] {
      PH_IDLE     = 17'b0_0000_0000_0000_0001,
      PH_ST1      = 17'b0_0000_0000_0000_0010,
      PH_ST2      = 17'b0_0000_0000_0000_0100,
      PH_ST3      = 17'b0_0000_0000_0000_1000,
      PH_SP1      = 17'b0_0000_0000_0001_0000,
      PH_SP2      = 17'b0_0000_0000_0010_0000,
      PH_SP3      = 17'b0_0000_0000_0100_0000,
      PH_WLOW     = 17'b0_0000_0000_1000_0000,
      PH_WHIGH    = 17'b0_0000_0001_0000_0000,
      PH_WACK     = 17'b0_0000_0010_0000_0000,
      PH_WPOLL    = 17'b0_0000_0100_0000_0000,
      PH_RLOW     = 17'b0_0000_1000_0000_0000,
      PH_RHIGH    = 17'b0_0001_0000_0000_0000,
      PH_RACKLOW  = 17'b0_0010_0000_0000_0000,
      PH_RACKHIGH = 17'b0_0100_0000_0000_0000,
      PH_RACKEND  = 17'b0_1000_0000_0000_0000,
      PH_WAITMS   = 17'b1_0000_0000_0000_0000
   } i2cm_phase_type;

   i2cm_phase_type      phase_ff, phase_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [BIDX_W-1:0]   bit_index_ff, bit_index_in;
   logic [TICK_W-1:0]   timer_ff, timer_in;
   logic [LIMIT_W-1:0]  poll_count_ff, poll_count_in;
   logic [MS_W-1:0]     ms_left_ff, ms_left_in;
   logic                ack_flag_ff, ack_flag_in;
   logic                ack_request_ff, ack_request_in;
   logic                scl_ok_ff, scl_ok_in;
   logic [BYTE_W-1:0]   last_read_ff, last_read_in;
   logic                scl_low_ff, scl_low_in;
   logic                sda_low_ff, sda_low_in;
   logic                done;

   logic [TICK_W-1:0]   half;
   logic [TICK_W-1:0]   cond;
   logic                expire;
   logic [BIDX_W-1:0]   bit_next;
   logic [BYTE_W-1:0]   shift_write;
   logic [BYTE_W-1:0]   shift_read;
   logic [LIMIT_W-1:0]  poll_next;

   assign half        = period(cfg.half_bit_ticks);
   assign cond        = period(cfg.condition_ticks);
   // A loaded delay always holds at least one, so the step falls due at one.
   assign expire      = (timer_ff == {{(TICK_W-1){1'b0}}, 1'b1});
   assign bit_next    = bit_index_ff + {{(BIDX_W-1){1'b0}}, 1'b1};
   assign shift_write = {shift_ff[BYTE_W-2:0], 1'b0};
   assign shift_read  = {shift_ff[BYTE_W-2:0], sda_in};
   assign poll_next   = poll_count_ff + {{(LIMIT_W-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in       = phase_ff;
      shift_in       = shift_ff;
      bit_index_in   = bit_index_ff;
      timer_in       = timer_ff;
      poll_count_in  = poll_count_ff;
      ms_left_in     = ms_left_ff;
      ack_flag_in    = ack_flag_ff;
      ack_request_in = ack_request_ff;
      scl_ok_in      = scl_ok_ff;
      last_read_in   = last_read_ff;
      scl_low_in     = scl_low_ff;
      sda_low_in     = sda_low_ff;
      done           = 1'b0;

      if (phase_ff == PH_IDLE) begin
         case (i2cm_action_type'(action))
            ACT_START: begin
               scl_low_in = 1'b0;
               sda_low_in = 1'b0;
               timer_in   = cond;
               phase_in   = PH_ST1;
            end
            ACT_STOP: begin
               sda_low_in = 1'b1;
               timer_in   = cond;
               phase_in   = PH_SP1;
            end
            ACT_WRITE: begin
               shift_in     = write_data;
               bit_index_in = '0;
               scl_low_in   = 1'b1;
               sda_low_in   = ~write_data[BYTE_W-1];
               timer_in     = half;
               phase_in     = PH_WLOW;
            end
            ACT_READ: begin
               shift_in       = '0;
               bit_index_in   = '0;
               ack_request_in = send_ack;
               scl_low_in     = 1'b1;
               sda_low_in     = 1'b0;
               timer_in       = half;
               phase_in       = PH_RLOW;
            end
            ACT_WAIT_SCL: begin
               if (wait_ms == '0) begin
                  scl_ok_in = 1'b0;
                  done      = 1'b1;
               end else begin
                  ms_left_in = wait_ms;
                  timer_in   = period(cfg.ms_ticks);
                  phase_in   = PH_WAITMS;
               end
            end
            default: begin
            end
         endcase
      end else begin
         timer_in = timer_ff - {{(TICK_W-1){1'b0}}, 1'b1};
         if (expire) begin
            case (phase_ff)
               PH_ST1: begin
                  sda_low_in = 1'b1; timer_in = cond; phase_in = PH_ST2;
               end
               PH_ST2: begin
                  scl_low_in = 1'b1; timer_in = cond; phase_in = PH_ST3;
               end
               PH_SP1: begin
                  scl_low_in = 1'b0; timer_in = cond; phase_in = PH_SP2;
               end
               PH_SP2: begin
                  sda_low_in = 1'b0; timer_in = cond; phase_in = PH_SP3;
               end
               PH_ST3, PH_SP3: begin
                  done = 1'b1;
               end
               PH_WLOW: begin
                  scl_low_in = 1'b0; timer_in = half; phase_in = PH_WHIGH;
               end
               PH_WHIGH: begin
                  scl_low_in   = 1'b1;
                  shift_in     = shift_write;
                  bit_index_in = bit_next;
                  timer_in     = half;
                  if (bit_next >= BITS_PER_BYTE) begin
                     sda_low_in = 1'b0;
                     phase_in   = PH_WACK;
                  end else begin
                     sda_low_in = ~shift_write[BYTE_W-1];
                     phase_in   = PH_WLOW;
                  end
               end
               PH_WACK: begin
                  scl_low_in    = 1'b0;
                  poll_count_in = '0;
                  timer_in      = period(cfg.ack_poll_ticks);
                  phase_in      = PH_WPOLL;
               end
               PH_WPOLL: begin
                  // A limit of zero wraps the count and so allows 256 samples.
                  poll_count_in = poll_next;
                  if (!sda_in) begin
                     ack_flag_in = 1'b1; scl_low_in = 1'b1; done = 1'b1;
                  end else if (poll_next == cfg.ack_poll_limit) begin
                     ack_flag_in = 1'b0; scl_low_in = 1'b1; done = 1'b1;
                  end else begin
                     timer_in = period(cfg.ack_poll_ticks);
                  end
               end
               PH_RLOW: begin
                  scl_low_in = 1'b0; timer_in = half; phase_in = PH_RHIGH;
               end
               PH_RHIGH: begin
                  shift_in     = shift_read;
                  scl_low_in   = 1'b1;
                  bit_index_in = bit_next;
                  timer_in     = half;
                  if (bit_next >= BITS_PER_BYTE) begin
                     last_read_in = shift_read;
                     if (ack_request_ff) begin
                        sda_low_in = 1'b1;
                     end
                     phase_in = PH_RACKLOW;
                  end else begin
                     phase_in = PH_RLOW;
                  end
               end
               PH_RACKLOW: begin
                  scl_low_in = 1'b0; timer_in = half; phase_in = PH_RACKHIGH;
               end
               PH_RACKHIGH: begin
                  scl_low_in = 1'b1; timer_in = half; phase_in = PH_RACKEND;
               end
               PH_RACKEND: begin
                  sda_low_in = 1'b0; done = 1'b1;
               end
               PH_WAITMS: begin
                  if (scl_in) begin
                     scl_ok_in = 1'b1; done = 1'b1;
                  end else begin
                     ms_left_in = ms_left_ff - {{(MS_W-1){1'b0}}, 1'b1};
                     if (ms_left_ff == {{(MS_W-1){1'b0}}, 1'b1}) begin
                        scl_ok_in = 1'b0; done = 1'b1;
                     end else begin
                        timer_in = period(cfg.ms_ticks);
                     end
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   always_comb begin
      result.scl_drive_low = scl_low_in;
      result.sda_drive_low = sda_low_in;
      result.busy_res      = (phase_in != PH_IDLE);
      result.done_res      = done;
      result.ack_seen      = ack_flag_in;
      result.scl_released  = scl_ok_in;
      result.read_data     = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         shift_ff       <= '0;
         bit_index_ff   <= '0;
         timer_ff       <= '0;
         poll_count_ff  <= '0;
         ms_left_ff     <= '0;
         ack_flag_ff    <= 1'b0;
         ack_request_ff <= 1'b0;
         scl_ok_ff      <= 1'b0;
         last_read_ff   <= '0;
         scl_low_ff     <= 1'b0;
         sda_low_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         shift_ff       <= shift_in;
         bit_index_ff   <= bit_index_in;
         timer_ff       <= timer_in;
         poll_count_ff  <= poll_count_in;
         ms_left_ff     <= ms_left_in;
         ack_flag_ff    <= ack_flag_in;
         ack_request_ff <= ack_request_in;
         scl_ok_ff      <= scl_ok_in;
         last_read_ff   <= last_read_in;
         scl_low_ff     <= scl_low_in;
         sda_low_ff     <= sda_low_in;
      end
   end

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("sequencer phase is not one-hot");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> phase_ff == PH_IDLE)
      else $error("completed command did not return to idle");

   a_timer_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> timer_ff != '0)
      else $error("busy phase with an empty tick timer");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= BITS_PER_BYTE)
      else $error("bit index ran past one byte");

endmodule

`default_nettype wire

[hw/rtl/i2c_bit_level_master_top.sv]
// Top level of the I2C bit level master: configuration registers, sequencer and result skid.
// Depends on i2cm_pkg and i2cm_core.
//
//   channel | direction | handshake          | carries
//   req_    | in        | req_valid/req_stall | one timer tick: command and sampled lines
//   rsp_    | out       | rsp_valid/rsp_stall | line drives and status after that tick
//   csr_    | in        | csr_valid/csr_ready | register index and write data
//
// One tick is accepted per clock while req_stall is low; its result is registered.
// A two-entry output (result register plus skid register) holds one tick accepted behind
// a stalled result; req_stall rises only once the skid register is occupied.
// Synchronous active high reset releases both lines and returns the sequencer to idle.
// csr_ready is always high; writes should be made while no command is running.
`default_nettype none

module i2c_bit_level_master_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_send_ack,
   input  wire logic [14:0] req_wait_ms,
   input  wire logic        req_sda_in,
   input  wire logic        req_scl_in,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_drive_low,
   output logic             rsp_sda_drive_low,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic             rsp_ack_seen,
   output logic             rsp_scl_released,
   output logic [7:0]       rsp_read_data,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import i2cm_pkg::*;

   i2cm_cfg_type    cfg_ff;
   i2cm_result_type step_result;
   i2cm_result_type out_ff;
   i2cm_result_type skid_ff;
   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic            accept;
   logic            out_take;
   logic            out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_ticks  <= HALF_BIT_RESET;
         cfg_ff.condition_ticks <= CONDITION_RESET;
         cfg_ff.ack_poll_ticks  <= ACK_POLL_RESET;
         cfg_ff.ack_poll_limit  <= POLL_LIMIT_RESET;
         cfg_ff.ms_ticks        <= MS_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (i2cm_csr_type'(csr_index))
            CSR_HALF_BIT:   cfg_ff.half_bit_ticks  <= csr_wdata;
            CSR_CONDITION:  cfg_ff.condition_ticks <= csr_wdata;
            CSR_ACK_POLL:   cfg_ff.ack_poll_ticks  <= csr_wdata;
            CSR_POLL_LIMIT: cfg_ff.ack_poll_limit  <= csr_wdata[LIMIT_W-1:0];
            CSR_MS_TICKS:   cfg_ff.ms_ticks        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || out_take;

   i2cm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .action     (req_action),
      .write_data (req_write_data),
      .send_ack   (req_send_ack),
      .wait_ms    (req_wait_ms),
      .sda_in     (req_sda_in),
      .scl_in     (req_scl_in),
      .cfg        (cfg_ff),
      .result     (step_result)
   );

   // Valid bits of the result register and the skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= !out_free;
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_free) begin
            out_ff <= step_result;
         end else begin
            skid_ff <= step_result;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_scl_drive_low = out_ff.scl_drive_low;
   assign rsp_sda_drive_low = out_ff.sda_drive_low;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_done_res      = out_ff.done_res;
   assign rsp_ack_seen      = out_ff.ack_seen;
   assign rsp_scl_released  = out_ff.scl_released;
   assign rsp_read_data     = out_ff.read_data;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("transaction accepted behind a stalled result was not kept");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_take |=> out_valid_ff && !skid_valid_ff)
      else $error("skid register did not move into the output register");

endmodule

`default_nettype wire
